>>> rtl/hsd_pkg.sv
// Shared types, constants and the Hall code table of the sector decoder.
package hsd_pkg;

	localparam int ROT_W     = 32;
	localparam int TOTAL_W   = ROT_W + 4;
	localparam int CPR_W     = 9;
	localparam int REM_W     = 9;
	localparam int PP_W      = 7;
	localparam int CNT_W     = $clog2(TOTAL_W);
	localparam int TIME_W    = 32;

	localparam logic [PP_W-1:0] PP_MIN   = PP_W'(1);
	localparam logic [PP_W-1:0] PP_MAX   = PP_W'(64);
	localparam logic [PP_W-1:0] PP_RESET = PP_W'(1);

	localparam logic signed [3:0] SECTOR_NONE = -4'sd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STEP,
		S_AGE,
		S_DIFF,
		S_STALE,
		S_SUM,
		S_START,
		S_DIV,
		S_FIX
	} hsd_fsm_t;

	typedef struct packed {
		logic step;
		logic age;
		logic diff;
		logic stale;
	} hsd_trk_ctl_t;

	typedef struct packed {
		logic signed [3:0]  sector;
		logic [ROT_W-1:0]   rev;
		logic               dir;
		logic [TIME_W-1:0]  period;
		logic [TIME_W-1:0]  stamp;
		logic               seq_ok;
	} hsd_state_t;

	function automatic logic signed [3:0] sector_of(input logic [2:0] code);
		logic signed [3:0] s;
		unique case (code)
			3'd1:    s = 4'sd0;
			3'd2:    s = 4'sd4;
			3'd3:    s = 4'sd5;
			3'd4:    s = 4'sd2;
			3'd5:    s = 4'sd1;
			3'd6:    s = 4'sd3;
			default: s = SECTOR_NONE;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/hsd_in_if.sv
// Sample channel: Hall line levels and timestamp.
interface hsd_in_if;
	logic        valid;
	logic        ready;
	logic        hall_a;
	logic        hall_b;
	logic        hall_c;
	logic [31:0] now_us;

	modport source (output valid, hall_a, hall_b, hall_c, now_us, input ready);
	modport sink   (input valid, hall_a, hall_b, hall_c, now_us, output ready);
endinterface

>>> rtl/hsd_out_if.sv
// Result channel: decoded position and timing.
interface hsd_out_if;
	logic               valid;
	logic               ready;
	logic signed [3:0]  sector;
	logic signed [31:0] electric_rotations;
	logic signed [9:0]  angle_count;
	logic signed [31:0] mech_turns;
	logic               direction;
	logic [31:0]        period_us;
	logic [31:0]        edge_time_us;
	logic               sequence_valid;

	modport source (output valid, sector, electric_rotations, angle_count, mech_turns,
		direction, period_us, edge_time_us, sequence_valid, input ready);
	modport sink   (input valid, sector, electric_rotations, angle_count, mech_turns,
		direction, period_us, edge_time_us, sequence_valid, output ready);
endinterface

>>> rtl/hsd_cfg_if.sv
// Configuration write channel for the pole pair count.
interface hsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> rtl/hall_sensor_sector_decoder_top.sv
// Top level of the Hall sensor sector decoder with its sequencer and output register.
// From acceptance to result a sample passes the step decode, the age, difference and stale
// steps and the position sum; then the restoring divider resolves one quotient bit per
// cycle of (rotations*6 + sector) by six times pole_pairs. The sample channel is ready
// only while the sequencer is idle; a finished result waits in the output register while
// the next sample is taken. The pole pair count is written on its own channel; the user
// must write it only while idle, which the block itself does not enforce.
// 0 is taken as 1 and values above 64 as 64.
module hall_sensor_sector_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	hsd_in_if.sink    samples,
	hsd_out_if.source results,
	hsd_cfg_if.sink   cfg
);
	import hsd_pkg::*;

	hsd_fsm_t                 state_q;
	hsd_fsm_t                 state_d;
	hsd_trk_ctl_t             ctl;
	hsd_state_t               st;

	logic [PP_W-1:0]          pole_pairs_q;
	logic [PP_W-1:0]          pp_eff;
	logic [CPR_W-1:0]         cpr;
	logic [2:0]               code_q;
	logic [TIME_W-1:0]        now_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [TOTAL_W-1:0] rot_ext;
	logic signed [TOTAL_W-1:0] sum;
	logic [TOTAL_W-1:0]       mag;
	logic                     neg;
	logic                     div_start;
	logic                     div_done;
	logic [TOTAL_W-1:0]       div_quo;
	logic [REM_W-1:0]         div_rem;
	logic signed [TOTAL_W-1:0] quo_s;
	logic signed [9:0]        rem_s;
	logic                     out_free;
	logic                     load_out;
	logic                     out_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pole_pairs_q <= PP_RESET;
		else if (cfg.valid)
			pole_pairs_q <= cfg.data;
	end

	always_comb begin
		if (pole_pairs_q < PP_MIN)
			pp_eff = PP_MIN;
		else if (pole_pairs_q > PP_MAX)
			pp_eff = PP_MAX;
		else
			pp_eff = pole_pairs_q;
		cpr = (CPR_W'(pp_eff) << 2) + (CPR_W'(pp_eff) << 1);
	end

	assign samples.ready = state_q == S_IDLE;

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			code_q <= {samples.hall_a, samples.hall_b, samples.hall_c};
			now_q  <= samples.now_us;
		end
	end

	hsd_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.code   (code_q),
		.now    (now_q),
		.st     (st)
	);

	always_comb begin
		rot_ext = TOTAL_W'($signed(st.rev));
		sum     = (rot_ext <<< 2) + (rot_ext <<< 1) + TOTAL_W'(st.sector);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUM)
			total_q <= sum;
	end

	assign neg = total_q[TOTAL_W-1];
	assign mag = neg ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);

	hsd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag),
		.divisor   (cpr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// remainder takes the sign of the dividend under truncating division
	assign quo_s = neg ? -$signed(div_quo) : $signed(div_quo);
	assign rem_s = neg ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});

	assign out_free = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE:  if (samples.valid) state_d = S_STEP;
			S_STEP:  begin
				ctl.step = 1'b1;
				state_d  = S_AGE;
			end
			S_AGE:   begin
				ctl.age = 1'b1;
				state_d = S_DIFF;
			end
			S_DIFF:  begin
				ctl.diff = 1'b1;
				state_d  = S_STALE;
			end
			S_STALE: begin
				ctl.stale = 1'b1;
				state_d   = S_SUM;
			end
			S_SUM:   state_d = S_START;
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV:   if (div_done) state_d = S_FIX;
			S_FIX:   if (out_free) begin
				load_out = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			results.sector             <= st.sector;
			results.electric_rotations <= 32'($signed(st.rev));
			results.angle_count        <= rem_s;
			results.mech_turns         <= 32'(quo_s);
			results.direction          <= st.dir;
			results.period_us          <= st.period;
			results.edge_time_us       <= st.stamp;
			results.sequence_valid     <= st.seq_ok;
		end
	end

	assign results.valid = out_valid_q;
endmodule

>>> rtl/hsd_div.sv
// Restoring divider: one quotient bit per cycle of a magnitude by the count per turn.
module hsd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hsd_pkg::TOTAL_W-1:0]  dividend,
	input  logic [hsd_pkg::CPR_W-1:0]    divisor,
	output logic                         done,
	output logic [hsd_pkg::TOTAL_W-1:0]  quotient,
	output logic [hsd_pkg::REM_W-1:0]    remainder
);
	import hsd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TOTAL_W-1:0]   quo_q;
	logic [REM_W-1:0]     rem_q;
	logic [CPR_W-1:0]     div_q;
	logic [REM_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[TOTAL_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(TOTAL_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when it fits
			quo_q <= {quo_q[TOTAL_W-2:0], ge};
			rem_q <= ge ? REM_W'(trial - {1'b0, div_q}) : REM_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

>>> rtl/hsd_track.sv
// Sector tracking state: step decode, revolution count, edge timing and stale check.
module hsd_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hsd_pkg::hsd_trk_ctl_t       ctl,
	input  logic [2:0]                  code,
	input  logic [hsd_pkg::TIME_W-1:0]  now,
	output hsd_pkg::hsd_state_t         st
);
	import hsd_pkg::*;

	logic               primed_q;
	logic [2:0]         code_q;
	logic signed [3:0]  sector_q;
	logic [ROT_W-1:0]   rev_q;
	logic               dir_q;
	logic [TIME_W-1:0]  period_q;
	logic [TIME_W-1:0]  stamp_q;
	logic               seq_ok_q;
	logic [TIME_W-1:0]  age_q;
	logic [TIME_W-1:0]  diff_q;
	logic               gt_q;

	logic signed [3:0]  ns;
	logic signed [3:0]  d_raw;
	logic signed [3:0]  delta;
	logic               fwd;
	logic               rev;

	always_comb begin
		ns    = sector_of(code);
		d_raw = ns - sector_q;
		delta = (d_raw < 0) ? d_raw + 4'sd6 : d_raw;
		fwd   = delta == 4'sd1;
		rev   = delta == 4'sd5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			code_q   <= '0;
			sector_q <= SECTOR_NONE;
			rev_q    <= '0;
			dir_q    <= 1'b0;
			period_q <= '0;
			stamp_q  <= '0;
			seq_ok_q <= 1'b0;
		end else if (ctl.step) begin
			if (!primed_q) begin
				primed_q <= 1'b1;
				code_q   <= code;
				sector_q <= ns;
				rev_q    <= '0;
				period_q <= '0;
				stamp_q  <= now;
				seq_ok_q <= ns >= 0;
			end else if (code != code_q) begin
				code_q <= code;
				if (ns < 0) begin
					seq_ok_q <= 1'b0;
				end else if (sector_q < 0) begin
					// adopt the sector again after it was lost
					sector_q <= ns;
					seq_ok_q <= 1'b0;
				end else if (!fwd && !rev) begin
					seq_ok_q <= 1'b0;
				end else begin
					if (sector_q == 4'sd5 && ns == 4'sd0)
						rev_q <= rev_q + ROT_W'(1);
					if (sector_q == 4'sd0 && ns == 4'sd5)
						rev_q <= rev_q - ROT_W'(1);
					sector_q <= ns;
					period_q <= (rev == dir_q) ? now - stamp_q : '0;
					stamp_q  <= now;
					dir_q    <= rev;
				end
			end
		end else if (ctl.stale) begin
			if (period_q != '0 && gt_q && diff_q > period_q)
				period_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.age)
			age_q <= now - stamp_q;
		if (ctl.diff) begin
			gt_q   <= age_q > period_q;
			diff_q <= age_q - period_q;
		end
	end

	always_comb begin
		st.sector = sector_q;
		st.rev    = rev_q;
		st.dir    = dir_q;
		st.period = period_q;
		st.stamp  = stamp_q;
		st.seq_ok = seq_ok_q;
	end
endmodule

>>> tb/sv/hsd_position_checker.sv
`timescale 1ns / 100ps
// Checker for the Hall sector decoder: predicts each result from the accepted samples and compares.
module hsd_position_checker (
	input  logic clk,
	input  logic arst_n,
	hsd_in_if    samples,
	hsd_out_if   results,
	hsd_cfg_if   cfg,
	output int   errors,
	output int   checked,
	output int   pending
);
	import hsd_pkg::*;

	typedef struct packed {
		logic signed [3:0]  sector;
		logic signed [31:0] rotations;
		logic signed [9:0]  angle;
		logic signed [31:0] turns;
		logic               dir;
		logic [31:0]        period;
		logic [31:0]        stamp;
		logic               seq_ok;
	} hsd_expect_t;

	localparam logic signed [3:0] SECTOR_OF_CODE [0:7] = '{
		-4'sd1, 4'sd0, 4'sd4, 4'sd5, 4'sd2, 4'sd1, 4'sd3, -4'sd1
	};

	// tracked decoder state
	logic               primed_q;
	logic [2:0]         code_q;
	logic signed [3:0]  sect_q;
	logic signed [31:0] rev_q;
	logic               dir_q;
	logic [31:0]        period_q;
	logic [31:0]        stamp_q;
	logic               seq_q;
	logic [PP_W-1:0]    pp_q;

	hsd_expect_t expected_positions[$];
	hsd_expect_t head;

	function automatic hsd_expect_t decode_sample(input logic [2:0] code, input logic [31:0] now);
		logic signed [3:0] ns;
		logic signed [3:0] os;
		int                delta;
		logic              ndir;
		logic [31:0]       age;
		longint            pp;
		longint            cpr;
		longint            total;
		hsd_expect_t       e;
		if (!primed_q) begin
			primed_q = 1'b1;
			code_q   = code;
			sect_q   = SECTOR_OF_CODE[code];
			rev_q    = '0;
			period_q = '0;
			stamp_q  = now;
			seq_q    = (sect_q >= 0);
		end else if (code != code_q) begin
			code_q = code;
			ns     = SECTOR_OF_CODE[code];
			os     = sect_q;
			if (ns < 0) begin
				seq_q = 1'b0;
			end else if (os < 0) begin
				// adopt the sector again after it was lost
				sect_q = ns;
				seq_q  = 1'b0;
			end else begin
				delta = (int'(ns) - int'(os) + 6) % 6;
				if (delta != 1 && delta != 5) begin
					seq_q = 1'b0;
				end else begin
					ndir = (delta == 5);
					if (os == 5 && ns == 0)
						rev_q = rev_q + 1;
					if (os == 0 && ns == 5)
						rev_q = rev_q - 1;
					sect_q   = ns;
					period_q = (ndir == dir_q) ? now - stamp_q : 32'd0;
					stamp_q  = now;
					dir_q    = ndir;
				end
			end
		end
		// drop a stale period on every sample
		age = now - stamp_q;
		if (period_q != 0 && age > period_q && age - period_q > period_q)
			period_q = '0;
		pp = pp_q;
		if (pp < PP_MIN)
			pp = PP_MIN;
		if (pp > PP_MAX)
			pp = PP_MAX;
		cpr   = pp * 6;
		total = longint'(rev_q) * 6 + longint'(sect_q);
		e.sector    = sect_q;
		e.rotations = rev_q;
		e.angle     = 10'(total % cpr);
		e.turns     = 32'(total / cpr);
		e.dir       = dir_q;
		e.period    = period_q;
		e.stamp     = stamp_q;
		e.seq_ok    = seq_q;
		return e;
	endfunction

	function automatic void field_check(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q = 1'b0;
			code_q   = '0;
			sect_q   = SECTOR_NONE;
			rev_q    = '0;
			dir_q    = 1'b0;
			period_q = '0;
			stamp_q  = '0;
			seq_q    = 1'b0;
			pp_q     = PP_RESET;
			expected_positions.delete();
			errors   = 0;
			checked  = 0;
			pending  = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				pp_q = cfg.data;
			if (results.valid && results.ready) begin
				if (expected_positions.size() == 0) begin
					errors++;
					$display("%0t: result transaction with no sample outstanding", $time);
				end else begin
					head = expected_positions.pop_front();
					field_check("sector", head.sector, results.sector);
					field_check("electric_rotations", head.rotations, results.electric_rotations);
					field_check("angle_count", head.angle, results.angle_count);
					field_check("mech_turns", head.turns, results.mech_turns);
					field_check("direction", head.dir, results.direction);
					field_check("period_us", head.period, results.period_us);
					field_check("edge_time_us", head.stamp, results.edge_time_us);
					field_check("sequence_valid", head.seq_ok, results.sequence_valid);
					checked++;
				end
			end
			if (samples.valid && samples.ready)
				expected_positions.push_back(decode_sample(
					{samples.hall_a, samples.hall_b, samples.hall_c}, samples.now_us));
			pending = expected_positions.size();
		end
	end

endmodule

>>> tb/sv/hall_sensor_sector_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Hall sector decoder: clock, reset, stimulus, back pressure and verdict.
module hall_sensor_sector_decoder_top_tb;

	localparam int HOLD_CYCLES  = 500;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE       = 50;
	localparam int PHASE_ITEMS  = 210;

	localparam logic [2:0] CODE_OF_SECTOR [0:5] = '{3'd1, 3'd5, 3'd4, 3'd6, 3'd2, 3'd3};

	logic clk;
	logic arst_n;

	hsd_in_if  samples_if ();
	hsd_out_if results_if ();
	hsd_cfg_if cfg_if ();

	int errors;
	int checked;
	int pending;

	int          sent;
	int          settings;
	int          hold_requests;
	int          holds_done;
	int          idle_cycles;
	bit          quiet;
	bit          fwd;
	int          walk;
	logic [31:0] t_now;

	hall_sensor_sector_decoder_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	hsd_position_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if),
		.errors  (errors),
		.checked (checked),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Offer one sample at a falling edge and hold it until accepted.
	task automatic put(input logic [2:0] code, input logic [31:0] t);
		if (!quiet && $urandom_range(99) < 10) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(negedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.hall_a <= code[2];
		samples_if.hall_b <= code[1];
		samples_if.hall_c <= code[0];
		samples_if.now_us <= t;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Drain all results, let the block settle, then write the pole pair count.
	task automatic set_pole_pairs(input logic [6:0] value);
		samples_if.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		settings++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(input int fwd_pct, input int base_gap, input int hold_at);
		int          r;
		int          r2;
		logic [2:0]  code;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i == hold_at)
				hold_requests++;
			if ($urandom_range(99) < 6)
				fwd = ($urandom_range(99) < fwd_pct);
			r2 = $urandom_range(99);
			if (r2 < 3)
				t_now = $urandom();
			else if (r2 < 10)
				t_now = t_now + base_gap * $urandom_range(3, 8);
			else
				t_now = t_now + base_gap + $urandom_range(0, base_gap / 4);
			r = $urandom_range(99);
			if (r < 68) begin
				walk = fwd ? (walk + 1) % 6 : (walk + 5) % 6;
				code = CODE_OF_SECTOR[walk];
			end else if (r < 80) begin
				code = CODE_OF_SECTOR[walk];
			end else if (r < 88) begin
				code = $urandom_range(1) ? 3'd7 : 3'd0;
			end else if (r < 95) begin
				// jump two to four sectors ahead; the walk stays where the block is
				code = CODE_OF_SECTOR[(walk + $urandom_range(2, 4)) % 6];
			end else begin
				code = 3'($urandom_range(7));
			end
			put(code, t_now);
		end
	endtask

	// Result side: random back pressure, plus one long hold-off on request.
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			results_if.ready <= (quiet || $urandom_range(99) >= 10);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (samples_if.valid && samples_if.ready)
			|| (results_if.valid && results_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.hall_a = 1'b0;
		samples_if.hall_b = 1'b0;
		samples_if.hall_c = 1'b0;
		samples_if.now_us = '0;
		cfg_if.valid      = 1'b0;
		cfg_if.data       = '0;
		sent          = 0;
		settings      = 0;
		hold_requests = 0;
		holds_done    = 0;
		quiet         = 1'b0;
		fwd           = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: invalid first sample, lost sector, both wraps, reversal, skip, stale, time wrap
		put(3'd7, 32'd0);
		put(3'd7, 32'd5);
		put(3'd0, 32'd10);
		put(3'd1, 32'd20);
		put(3'd5, 32'd100);
		put(3'd4, 32'd200);
		put(3'd6, 32'd300);
		put(3'd2, 32'd400);
		put(3'd3, 32'd500);
		put(3'd1, 32'd600);
		put(3'd3, 32'd700);
		put(3'd2, 32'd800);
		put(3'd4, 32'd900);
		put(3'd6, 32'd1000);
		put(3'd6, 32'd1700);
		put(3'd4, 32'd1800);
		put(3'd5, 32'd1900);
		put(3'd1, 32'd2000);
		put(3'd3, 32'd2100);
		put(3'd2, 32'd2200);
		put(3'd2, 32'hFFFF_FFFF);
		put(3'd6, 32'h0000_0005);
		put(3'd7, 32'hFFFF_FFFF);
		put(3'd6, 32'h0000_0100);
		walk = 3;

		set_pole_pairs(7'd64);
		t_now = $urandom();
		run_phase(85, 200, -1);
		set_pole_pairs(7'd0);
		run_phase(85, 40, 40);
		set_pole_pairs(7'd127);
		run_phase(85, 1500, -1);
		set_pole_pairs(7'd65);
		quiet = 1'b1;
		run_phase(85, 25, -1);
		quiet = 1'b0;
		set_pole_pairs(7'd1);
		run_phase(15, 300, -1);
		set_pole_pairs(7'($urandom_range(1, 64)));
		run_phase(15, 800, -1);
		set_pole_pairs(7'd7);
		run_phase(15, 60, -1);
		set_pole_pairs(7'd33);
		run_phase(50, 3000, -1);

		samples_if.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d samples, checked %0d results over %0d pole pair settings.",
			sent, checked, settings);
		$display("Included a %0d-cycle receiver hold-off and a stretch without idling.",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/hsd_pkg.sv
rtl/hsd_in_if.sv
rtl/hsd_out_if.sv
rtl/hsd_cfg_if.sv
rtl/hsd_div.sv
rtl/hsd_track.sv
rtl/hall_sensor_sector_decoder_top.sv
tb/sv/hsd_position_checker.sv
tb/sv/hall_sensor_sector_decoder_top_tb.sv
